>>> sv/lkvc_pkg.sv
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE     = '1;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } t_cmd;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [IDX_W-1:0] t_rank;
    typedef logic [KEY_W-1:0] t_key;
    typedef logic [VAL_W-1:0] t_val;
    typedef logic [CNT_W-1:0] t_cnt;

    // Update plan for one request, from the lookup to the store.
    typedef struct packed {
        logic  hit;        // key present
        logic  promote;    // move slot to rank 0, age the others
        logic  write_val;  // store the request value at slot
        logic  write_key;  // store the request key at slot (insert)
        logic  grow;       // insert into a free slot: all entries age
        t_idx  slot;
        t_rank limit;      // entries more recent than this age by one
    } t_plan;

endpackage

>>> sv/lkvc_match.sv
module lkvc_match (
    input  lkvc_pkg::t_cmd               i_command,
    input  lkvc_pkg::t_key               i_key,
    input  logic [lkvc_pkg::CAP_W-1:0]   i_capacity,
    input  lkvc_pkg::t_key               i_keys [lkvc_pkg::ENTRIES],
    input  logic [lkvc_pkg::ENTRIES-1:0] i_valid,
    input  lkvc_pkg::t_rank              i_rank [lkvc_pkg::ENTRIES],
    input  lkvc_pkg::t_cnt               i_held,
    output lkvc_pkg::t_plan              o_plan
);
    import lkvc_pkg::*;

    logic               w_hit;
    t_idx               w_hit_slot;
    t_rank              w_hit_rank;
    t_idx               w_free_slot;
    t_idx               w_old_slot;
    t_rank              w_oldest;
    logic [CMP_W-1:0]   w_cap;
    logic [CMP_W-1:0]   w_eff;
    logic               w_full;
    logic               w_put;

    // zero acts as one, anything above the array size as the array size
    assign w_cap    = CMP_W'(i_capacity);
    assign w_eff    = (w_cap == '0) ? CMP_W'(1) :
                      (w_cap > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : w_cap;
    assign w_full   = CMP_W'(i_held) >= w_eff;
    assign w_oldest = IDX_W'(i_held - CNT_W'(1));
    assign w_put    = (i_command == CMD_PUT);

    // descending scan: the lowest matching index wins
    always_comb begin
        w_hit       = 1'b0;
        w_hit_slot  = '0;
        w_hit_rank  = '0;
        w_free_slot = '0;
        w_old_slot  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (i_valid[i] && (i_keys[i] == i_key)) begin
                w_hit      = 1'b1;
                w_hit_slot = IDX_W'(i);
                w_hit_rank = i_rank[i];
            end
            if (!i_valid[i]) begin
                w_free_slot = IDX_W'(i);
            end
            if (i_valid[i] && (i_rank[i] == w_oldest)) begin
                w_old_slot = IDX_W'(i);
            end
        end
    end

    always_comb begin
        o_plan.hit       = w_hit;
        o_plan.promote   = w_hit || w_put;
        o_plan.write_val = w_put;
        o_plan.write_key = w_put && !w_hit;
        o_plan.grow      = w_put && !w_hit && !w_full;
        o_plan.slot      = w_hit ? w_hit_slot : (w_full ? w_old_slot : w_free_slot);
        o_plan.limit     = w_hit ? w_hit_rank : w_oldest;
    end

endmodule

>>> sv/lkvc_store.sv
module lkvc_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  logic                         i_apply,
    input  lkvc_pkg::t_plan              i_plan,
    input  lkvc_pkg::t_key               i_key,
    input  lkvc_pkg::t_val               i_value,
    output lkvc_pkg::t_key               o_keys [lkvc_pkg::ENTRIES],
    output logic [lkvc_pkg::ENTRIES-1:0] o_valid,
    output lkvc_pkg::t_rank              o_rank [lkvc_pkg::ENTRIES],
    output lkvc_pkg::t_cnt               o_held,
    output lkvc_pkg::t_val               o_slot_value
);
    import lkvc_pkg::*;

    t_key               r_keys   [ENTRIES];
    t_val               r_values [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    t_rank              r_rank   [ENTRIES];
    t_cnt               r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
            r_held  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_apply && i_plan.promote) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (r_valid[i] && (IDX_W'(i) != i_plan.slot) &&
                    (i_plan.grow || (r_rank[i] < i_plan.limit))) begin
                    r_rank[i] <= r_rank[i] + IDX_W'(1);
                end
            end
            r_rank[i_plan.slot] <= '0;
            if (i_plan.grow) begin
                r_valid[i_plan.slot] <= 1'b1;
                r_held               <= r_held + CNT_W'(1);
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_apply && i_plan.write_val) begin
            r_values[i_plan.slot] <= i_value;
        end
        if (i_apply && i_plan.write_key) begin
            r_keys[i_plan.slot] <= i_key;
        end
    end

    assign o_keys       = r_keys;
    assign o_valid      = r_valid;
    assign o_rank       = r_rank;
    assign o_held       = r_held;
    assign o_slot_value = r_values[i_plan.slot];

endmodule

>>> sv/lru_key_value_cache.sv
// A get's result reaches o_hit/o_read_value via the input and result registers.
// Throughput: one request per cycle while o_in_stall is low; lookup, rank update
// and write-back for an item all happen as it retires from the input register.
// A get waits only while the result register holds an untaken beat.
// Reset (synchronous, active low) empties the store and sets capacity to 16;
// a capacity write empties the store the same way.
module lru_key_value_cache (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_command,
    input  logic signed [31:0]         i_key,
    input  logic signed [31:0]         i_value,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_hit,
    output logic signed [31:0]         o_read_value,
    // capacity register
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0] i_cfg_capacity
);
    import lkvc_pkg::*;

    // input register
    logic             r_in_valid;
    t_cmd             r_command;
    t_key             r_key;
    t_val             r_value;

    // result register
    logic             r_out_valid;
    logic             r_hit;
    t_val             r_read_value;

    logic [CAP_W-1:0] r_capacity;

    logic             w_in_load;
    logic             w_adv;
    logic             w_emit;
    logic             w_cfg_wr;
    t_plan            w_plan;
    t_key             w_keys [ENTRIES];
    logic [ENTRIES-1:0] w_valid;
    t_rank            w_rank [ENTRIES];
    t_cnt             w_held;
    t_val             w_slot_value;

    // Always taken; the host must only write while the block is idle (unchecked).
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    // A put never produces a beat, so it retires regardless of the result side.
    // A get retires when the result register is empty or being drained.
    assign w_adv      = r_in_valid &&
                        ((r_command == CMD_PUT) || !r_out_valid || !i_out_stall);
    assign w_emit     = w_adv && (r_command == CMD_GET);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_load  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (w_cfg_wr) begin
            r_capacity <= i_cfg_capacity;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_load || (r_in_valid && !w_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load) begin
            r_command <= t_cmd'(i_command);
            r_key     <= i_key;
            r_value   <= i_value;
        end
    end

    // parallel compare over all entries, pick target slot
    lkvc_match u_match (
        .i_command  (r_command),
        .i_key      (r_key),
        .i_capacity (r_capacity),
        .i_keys     (w_keys),
        .i_valid    (w_valid),
        .i_rank     (w_rank),
        .i_held     (w_held),
        .o_plan     (w_plan)
    );

    // entry storage and recency ranks, updated on the retiring edge
    lkvc_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (w_cfg_wr),
        .i_apply      (w_adv),
        .i_plan       (w_plan),
        .i_key        (r_key),
        .i_value      (r_value),
        .o_keys       (w_keys),
        .o_valid      (w_valid),
        .o_rank       (w_rank),
        .o_held       (w_held),
        .o_slot_value (w_slot_value)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_emit || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_hit        <= w_plan.hit;
            r_read_value <= w_plan.hit ? w_slot_value : MISS_VALUE;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_hit;
    assign o_read_value = r_read_value;

    // a new result beat only comes from a retiring get
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_emit))
        else $error("result beat without a retiring get");

    // a miss always reads as all ones
    a_miss_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_read_value == MISS_VALUE))
        else $error("miss beat with wrong value");

    // a get behind a stalled result must hold the request side
    a_get_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_command == CMD_GET) && r_out_valid && i_out_stall)
        |-> o_in_stall)
        else $error("get retired over a stalled result");

    // an insert into a free slot never coincides with a hit
    a_plan_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_plan.hit) |-> !w_plan.grow)
        else $error("hit and insert in one plan");

endmodule

>>> dv/lru_read_tracker_pkg.sv
`timescale 1ns / 1ps

package lru_read_tracker_pkg;

    import lkvc_pkg::*;

    // One expected beat on the result channel.
    typedef struct {
        logic hit;
        t_val data;
    } t_read_beat;

    // Shadow of the cache contents plus the reads still owed by the block.
    class lru_read_tracker;

        t_key             keys [ENTRIES];
        t_val             vals [ENTRIES];
        bit               used [ENTRIES];
        int unsigned      age  [ENTRIES];   // 0 = most recently touched
        int unsigned      held;
        logic [CAP_W-1:0] cap;
        t_read_beat       pending_reads[$];
        int               mismatches;

        function new();
            cap        = CAPACITY_RESET;
            mismatches = 0;
            empty_store();
        endfunction

        function void empty_store();
            foreach (used[i]) begin
                used[i] = 1'b0;
                age[i]  = 0;
            end
            held = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            cap = value;
            empty_store();
        endfunction

        function int pending();
            return pending_reads.size();
        endfunction

        // Bring slot to the front; live entries younger than limit get one step older.
        function void touch(int slot, int unsigned limit);
            foreach (used[i])
                if (used[i] && i != slot && age[i] < limit)
                    age[i]++;
            age[slot] = 0;
        endfunction

        function int find_slot(t_key key);
            foreach (used[i])
                if (used[i] && keys[i] == key)
                    return i;
            return -1;
        endfunction

        // Accepted request beat: update the shadow, queue the read result if any.
        function void note_request(t_cmd cmd, t_key key, t_val data);
            int          slot;
            int unsigned room;
            int unsigned oldest;
            t_read_beat  beat;
            slot = find_slot(key);
            if (cmd == CMD_GET) begin
                if (slot >= 0) begin
                    touch(slot, age[slot]);
                    beat.hit  = 1'b1;
                    beat.data = vals[slot];
                end else begin
                    beat.hit  = 1'b0;
                    beat.data = MISS_VALUE;
                end
                pending_reads.push_back(beat);
                return;
            end
            if (slot >= 0) begin
                vals[slot] = data;
                touch(slot, age[slot]);
                return;
            end
            room = (cap == 0) ? 1 : (cap > ENTRIES) ? ENTRIES : cap;
            if (held < room)
                foreach (used[i])
                    if (slot < 0 && !used[i])
                        slot = i;
            if (slot >= 0) begin
                used[slot] = 1'b1;
                keys[slot] = key;
                vals[slot] = data;
                touch(slot, 32'hFFFF_FFFF);
                held++;
            end else begin
                // full: reuse the least recently touched slot
                oldest = 0;
                foreach (used[i])
                    if (used[i] && (slot < 0 || age[i] > oldest)) begin
                        slot   = i;
                        oldest = age[i];
                    end
                if (slot >= 0) begin
                    keys[slot] = key;
                    vals[slot] = data;
                    touch(slot, oldest);
                end
            end
        endfunction

        // Accepted result beat: compare against the oldest owed read.
        function void check_read(logic hit, t_val data);
            t_read_beat want;
            if (pending_reads.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: read beat with nothing owed: hit %0b read_value %h",
                             $realtime, hit, data);
                return;
            end
            want = pending_reads.pop_front();
            if (hit !== want.hit || data !== want.data) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: read mismatch: hit exp %0b got %0b, read_value exp %h got %h",
                             $realtime, want.hit, hit, want.data, data);
            end
        endfunction

    endclass

endpackage

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import lkvc_pkg::*;
    import lru_read_tracker_pkg::*;

    localparam int unsigned ITEM_TARGET    = 1150;
    localparam int unsigned HOLD_CYCLES    = 300;  // long sink back-pressure stretch
    localparam int unsigned PRESSURE_PHASE = 6;
    localparam int unsigned DRAIN_CYCLES   = 4;    // puts leave no beat

    // Capacity walk for the first random phases: nominal range ends, zero and
    // over-range (clamped by the block), a rewrite of the same value (must still
    // flush), then a few mid values.
    localparam logic [CAP_W-1:0] CAP_PLAN [12] = '{
        5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd4, 5'd16, 5'd16, 5'd2, 5'd8, 5'd15, 5'd3
    };

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_stall;
    logic               i_command      = CMD_GET;
    logic signed [31:0] i_key          = '0;
    logic signed [31:0] i_value        = '0;
    logic               o_out_valid;
    logic               i_out_stall    = 1'b0;
    logic               o_hit;
    logic signed [31:0] o_read_value;
    logic               i_cfg_valid    = 1'b0;
    logic               o_cfg_ready;
    logic [CAP_W-1:0]   i_cfg_capacity = CAPACITY_RESET;

    lru_key_value_cache DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_key          (i_key),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_read_value   (o_read_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_capacity (i_cfg_capacity)
    );

    lru_read_tracker tracker = new();

    // Traffic shaping knobs shared between the stimulus and the sink.
    bit               src_quiet    = 1'b0;  // sender runs back to back for a while
    bit               src_rush     = 1'b0;  // forced back to back (pressure phase)
    bit               sink_quiet   = 1'b0;  // sink takes every beat for a while
    bit               hold_request = 1'b0;  // ask the sink for one long hold
    int unsigned      items_sent   = 0;
    logic [CAP_W-1:0] cap_now      = CAPACITY_RESET;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the edge with pre-edge values,
    // same as the DUT sees them. Requests go into the shadow store, result
    // beats are checked against the owed reads.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            tracker.note_request(t_cmd'(i_command), i_key, i_value);
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_read(o_hit, o_read_value);
    end

    // ------------------------------------------------------------------
    // Result sink: a random stall before each beat, with stretches of no
    // stalling, and one long hold on request.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned pause;
        forever begin
            if (hold_request) begin
                pause        = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                if ($urandom_range(0, 29) == 0)
                    sink_quiet = !sink_quiet;
                pause = sink_quiet ? 0 : $urandom_range(0, 15);
            end
            if (pause != 0) begin
                i_out_stall <= 1'b1;
                repeat (pause) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(i_rst_n && o_out_valid && !i_out_stall));
        end
    end

    // ------------------------------------------------------------------
    // Request driver. valid stays up from one beat to the next when there
    // is no gap, so it is never dropped and raised in the same step.
    // ------------------------------------------------------------------
    task automatic issue(input t_cmd cmd, input t_key key, input t_val data);
        int unsigned gap;
        if ($urandom_range(0, 29) == 0)
            src_quiet = !src_quiet;
        gap = (src_quiet || src_rush) ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_key      <= key;
        i_value    <= data;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        items_sent++;
    endtask

    // Capacity write, only with the block quiet: no owed reads and a
    // DRAIN_CYCLES wait for a trailing put to land.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_cfg_capacity <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.set_capacity(cap);
        cap_now = cap;
    endtask

    // Key/value source: half random, half a corner pattern or a
    // one-hot word (keys that differ from each other in few bits).
    function automatic logic [31:0] corner_or_random();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            4:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // One random phase. Keys come from a pool a bit larger than the live
    // capacity so hits, updates and evictions all happen often; one request
    // in ten uses a fresh key.
    task automatic run_phase(input int unsigned count, input int unsigned get_pct);
        t_key        pool [24];
        int unsigned room;
        int unsigned pool_n;
        t_key        key;
        t_cmd        cmd;
        room   = (cap_now == 0) ? 1 : (cap_now > ENTRIES) ? ENTRIES : cap_now;
        pool_n = room + $urandom_range(1, 6);
        for (int i = 0; i < pool_n; i++)
            pool[i] = corner_or_random();
        for (int i = 0; i < count; i++) begin
            key = ($urandom_range(0, 9) == 0) ? t_key'($urandom)
                                              : pool[$urandom_range(0, pool_n - 1)];
            cmd = ($urandom_range(0, 99) < get_pct) ? CMD_GET : CMD_PUT;
            issue(cmd, key, corner_or_random());
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned      phase;
        logic [CAP_W-1:0] cap;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, capacity 16 out of reset.
        issue(CMD_GET, 32'h0000_0000, 32'h0);            // miss on empty store
        issue(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        issue(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        issue(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);    // key -1 storing -1
        issue(CMD_GET, 32'hFFFF_FFFF, 32'h0);            // hit, must not look like a miss
        issue(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        issue(CMD_GET, 32'h7FFF_FFFF, 32'h0);
        issue(CMD_PUT, 32'h8000_0000, 32'h0000_0000);    // update in place
        issue(CMD_GET, 32'h8000_0000, 32'h0);
        issue(CMD_GET, 32'h0000_0001, 32'h0);            // miss

        // Capacity 2: a get refreshes recency, so the other key is evicted.
        write_capacity(5'd2);
        issue(CMD_PUT, 32'h0000_0001, 32'h0000_0011);
        issue(CMD_PUT, 32'h0000_0002, 32'h0000_0022);
        issue(CMD_GET, 32'h0000_0001, 32'h0);
        issue(CMD_PUT, 32'h0000_0003, 32'h0000_0033);    // evicts key 2
        issue(CMD_GET, 32'h0000_0002, 32'h0);
        issue(CMD_GET, 32'h0000_0001, 32'h0);
        issue(CMD_GET, 32'h0000_0003, 32'h0);

        // Capacity 0 behaves as 1.
        write_capacity(5'd0);
        issue(CMD_PUT, 32'h0000_0005, 32'h0000_0055);
        issue(CMD_PUT, 32'h0000_0006, 32'h0000_0066);
        issue(CMD_GET, 32'h0000_0005, 32'h0);
        issue(CMD_GET, 32'h0000_0006, 32'h0);

        // Over-range capacity clamps to 16; the write flushes key 6.
        write_capacity(5'd31);
        issue(CMD_GET, 32'h0000_0006, 32'h0);
        issue(CMD_PUT, 32'h0000_0007, 32'h0000_0077);
        issue(CMD_GET, 32'h0000_0007, 32'h0);

        // Random phases, each under a new capacity.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase < 12)
                cap = CAP_PLAN[phase];
            else if ($urandom_range(0, 3) == 0)
                cap = CAP_W'($urandom_range(0, 31));
            else
                cap = CAP_W'($urandom_range(1, 16));
            write_capacity(cap);
            if (phase == PRESSURE_PHASE) begin
                // sink holds off while requests keep coming: input must stall
                hold_request = 1'b1;
                src_rush     = 1'b1;
                run_phase(80, 70);
                src_rush     = 1'b0;
            end else begin
                run_phase($urandom_range(40, 110), $urandom_range(35, 65));
            end
            phase++;
        end

        // Drain: all owed reads, then an idle wait for stray beats.
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
sv/lkvc_pkg.sv
sv/lkvc_match.sv
sv/lkvc_store.sv
sv/lru_key_value_cache.sv
dv/lru_read_tracker_pkg.sv
dv/tb_top.sv
